// ===== rtl/core/varint_zigzag_field_encoder_defines.svh =====
// Assertion macros shared by the field encoder RTL.
`ifndef VARINT_ZIGZAG_FIELD_ENCODER_DEFINES_SVH
`define VARINT_ZIGZAG_FIELD_ENCODER_DEFINES_SVH

// Expression holds at every clock edge outside reset.
`define VZFE_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define VZFE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/vzfe_pkg.sv =====
// Shared types and constants of the varint/zigzag field encoder.
`default_nettype none

package vzfe_pkg;

  // Field kinds as carried on the request channel.
  typedef enum logic [2:0] {
    KIND_FIX8  = 3'd0,
    KIND_FIX16 = 3'd1,
    KIND_FIX32 = 3'd2,
    KIND_FIX64 = 3'd3,
    KIND_VAR32 = 3'd4,
    KIND_VAR64 = 3'd5,
    KIND_ZZ32  = 3'd6,
    KIND_ZZ64  = 3'd7
  } kind_t;

  // Longest field: ten varint bytes for a 64-bit value.
  localparam int MAX_BYTES = 10;

  typedef logic [3:0] byte_cnt_t;

  // One classified field, bytes ordered low byte first in word.
  typedef struct packed {
    logic [63:0] word;
    byte_cnt_t   count;
    logic        varint;
  } desc_t;

endpackage

`default_nettype wire

// ===== rtl/core/vzfe_if.sv =====
// Valid/ready channel interfaces of the field encoder.
`default_nettype none

interface vzfe_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic [2:0]  kind;
  modport source (output valid, value, kind, input ready);
  modport sink   (input valid, value, kind, output ready);
endinterface

interface vzfe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;
  modport source (output valid, out_byte, last, input ready);
  modport sink   (input valid, out_byte, last, output ready);
endinterface

interface vzfe_cfg_if;
  logic valid;
  logic ready;
  logic little_endian;
  modport source (output valid, little_endian, input ready);
  modport sink   (input valid, little_endian, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/varint_zigzag_field_encoder.sv =====
// Top level of the varint/zigzag field encoder.
//
//   channel  | role   | payload                      | request meaning
//   ---------+--------+------------------------------+-------------------------------
//   cfg      | sink   | little_endian                | write the byte-order register
//   item     | sink   | value[63:0], kind[2:0]       | one field to serialize
//   result   | source | out_byte[7:0], last          | one serialized byte
//
// Rate: one output byte per cycle while result is not stalled; each field has its
// bytes (1, 2, 4 or 8 fixed, 1 to 10 varint) paced out by the back-end byte shifter.
// An item passes the queue slot, the back-end shift register and the output register.
// Reset (rst, synchronous) clears little_endian, the queue and the output valid,
// and holds cfg and item not ready.
// A stalled result holds its byte; items keep entering until the queue fills.
`default_nettype none

module varint_zigzag_field_encoder
  import vzfe_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic  clk,
  input  wire logic  rst,
  vzfe_cfg_if.sink   cfg,
  vzfe_in_if.sink    item,
  vzfe_out_if.source result
);

  logic  little_endian;
  logic  push;
  logic  pop;
  logic  full;
  logic  empty;
  desc_t push_desc;
  desc_t pop_desc;

  // Writes taken out of reset; the sender must write only while idle, unchecked.
  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      little_endian <= 1'b0;
    end else if (cfg.valid) begin
      little_endian <= cfg.little_endian;
    end
  end

  // Classify the request into a low-byte-first word plus a byte count.
  vzfe_front u_front (
    .little_endian (little_endian),
    .item          (item),
    .full          (full),
    .push          (push),
    .push_desc     (push_desc)
  );

  // Decouple request acceptance from byte output.
  vzfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .full      (full),
    .pop       (pop),
    .pop_desc  (pop_desc),
    .empty     (empty)
  );

  // Shift bytes out through the output register, flag the final one.
  vzfe_back u_back (
    .clk      (clk),
    .rst      (rst),
    .empty    (empty),
    .pop_desc (pop_desc),
    .pop      (pop),
    .result   (result)
  );

endmodule

`default_nettype wire

// ===== rtl/core/vzfe_front.sv =====
// Front end: accepts a request, applies zigzag/byte order and sizes the field.
`default_nettype none

module vzfe_front
  import vzfe_pkg::*;
(
  input  wire logic    little_endian,
  vzfe_in_if.sink      item,
  input  wire logic    full,
  output logic         push,
  output desc_t        push_desc
);

  logic [63:0] value;
  logic [63:0] rev64;
  logic [63:0] z;
  logic [31:0] zz32;
  byte_cnt_t   vcnt;

  assign value      = item.value;
  assign item.ready = !full;
  assign push       = item.valid && !full;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      rev64[8*i +: 8] = value[8*(7-i) +: 8];
    end
  end

  assign zz32 = {value[30:0], 1'b0} ^ {32{value[31]}};

  // Pick the varint source word.
  always_comb begin
    case (kind_t'(item.kind))
      KIND_VAR64: z = value;
      KIND_ZZ32:  z = {32'd0, zz32};
      KIND_ZZ64:  z = {value[62:0], 1'b0} ^ {64{value[63]}};
      default:    z = {32'd0, value[31:0]};
    endcase
  end

  // One byte per started 7-bit group; zero still takes one byte.
  always_comb begin
    vcnt = 4'd1;
    for (int k = 1; k < MAX_BYTES; k++) begin
      if ((z >> (7*k)) != 64'd0) begin
        vcnt = 4'(k + 1);
      end
    end
  end

  always_comb begin
    push_desc.word   = z;
    push_desc.count  = vcnt;
    push_desc.varint = 1'b1;
    case (kind_t'(item.kind))
      KIND_FIX8: begin
        push_desc.word   = {56'd0, value[7:0]};
        push_desc.count  = 4'd1;
        push_desc.varint = 1'b0;
      end
      KIND_FIX16: begin
        push_desc.word   = little_endian ? {48'd0, value[15:0]}
                                         : {48'd0, value[7:0], value[15:8]};
        push_desc.count  = 4'd2;
        push_desc.varint = 1'b0;
      end
      KIND_FIX32: begin
        push_desc.word   = little_endian ? {32'd0, value[31:0]}
                                         : {32'd0, rev64[63:32]};
        push_desc.count  = 4'd4;
        push_desc.varint = 1'b0;
      end
      KIND_FIX64: begin
        push_desc.word   = little_endian ? value : rev64;
        push_desc.count  = 4'd8;
        push_desc.varint = 1'b0;
      end
      default: begin
        push_desc.word   = z;
        push_desc.count  = vcnt;
        push_desc.varint = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/vzfe_queue.sv =====
// Short descriptor queue between front and back end.
`default_nettype none
`include "varint_zigzag_field_encoder_defines.svh"

module vzfe_queue
  import vzfe_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire desc_t  push_desc,
  output logic        full,
  input  wire logic   pop,
  output desc_t       pop_desc,
  output logic        empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  desc_t         slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  // Refuse requests while reset is held.
  assign full     = rst || (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign pop_desc = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `VZFE_ASSERT_ALWAYS(a_count_bound, count <= CW'(DEPTH), "queue count above depth")
  `VZFE_ASSERT_ALWAYS(a_no_pop_empty, !(pop && empty), "pop from empty queue")
  `VZFE_ASSERT_NEXT(a_pop_drains, pop && !push, count == CW'($past(count) - 1'b1), "pop lost")

endmodule

`default_nettype wire

// ===== rtl/core/vzfe_back.sv =====
// Back end: shifts one byte per cycle out of the current field while the result is not stalled.
`default_nettype none
`include "varint_zigzag_field_encoder_defines.svh"

module vzfe_back
  import vzfe_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   empty,
  input  wire desc_t  pop_desc,
  output logic        pop,
  vzfe_out_if.source  result
);

  logic [63:0] word;
  byte_cnt_t   rem;
  logic        varint;
  logic [7:0]  out_byte;
  logic        out_last;
  logic        out_valid;

  logic        take;
  logic        emit;
  logic        final_byte;
  logic [7:0]  byte_now;

  assign take       = !out_valid || result.ready;
  assign emit       = take && (rem != 4'd0);
  assign final_byte = (rem == 4'd1);
  // Varint continuation bit rides on every byte but the final one.
  assign byte_now   = varint ? {!final_byte, word[6:0]} : word[7:0];
  assign pop        = !empty && ((rem == 4'd0) || (emit && final_byte));

  assign result.valid    = out_valid;
  assign result.out_byte = out_byte;
  assign result.last     = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      rem       <= 4'd0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        rem <= pop_desc.count;
      end else if (emit) begin
        rem <= rem - 1'b1;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      word   <= pop_desc.word;
      varint <= pop_desc.varint;
    end else if (emit) begin
      word <= varint ? (word >> 7) : (word >> 8);
    end
    if (emit) begin
      out_byte <= byte_now;
      out_last <= final_byte;
    end
  end

  `VZFE_ASSERT_ALWAYS(a_rem_bound, rem <= 4'(MAX_BYTES), "byte count above field maximum")
  `VZFE_ASSERT_NEXT(a_last_flag, emit && final_byte, out_valid && out_last, "final byte not flagged")
  `VZFE_ASSERT_NEXT(a_hold_byte, out_valid && !result.ready, out_valid && $stable(out_byte) && $stable(out_last), "stalled byte changed")

endmodule

`default_nettype wire

// ===== tb/varint_zigzag_field_encoder_tb.sv =====
// Self-checking testbench of the varint/zigzag field encoder.
`default_nettype none

module varint_zigzag_field_encoder_tb;
  import vzfe_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Give up well past the slowest legal run: ~150 fields of up to ten bytes,
  // each byte waiting out random receiver stalls, plus the long hold-off.
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int PHASE_FIELDS = 31;
  localparam int MAX_REPORTS = 10;

  // One serialized byte as it appears on the result channel.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } ser_byte_t;

  // Track the byte order register, predict the bytes of every accepted
  // request and check each result byte against the oldest prediction.
  class field_bytes_sb;
    ser_byte_t pending_bytes[$];
    logic      lsb_first;
    int        fields_seen;
    int        bytes_checked;
    int        failures;

    function new();
      lsb_first = 1'b0;
      fields_seen = 0;
      bytes_checked = 0;
      failures = 0;
    endfunction

    function void set_byte_order(input logic le);
      lsb_first = le;
    endfunction

    function int outstanding();
      return pending_bytes.size();
    endfunction

    // Append one predicted byte at the tail of the queue.
    function void add_byte(input logic [7:0] data, input logic last);
      ser_byte_t b;
      b.data = data;
      b.last = last;
      pending_bytes.insert(pending_bytes.size(), b);
    endfunction

    function void push_fixed(input logic [63:0] v, input int nbytes);
      int idx;
      for (int k = 0; k < nbytes; k++) begin
        idx = lsb_first ? k : nbytes - 1 - k;
        add_byte(v[8*idx +: 8], (k == nbytes - 1));
      end
    endfunction

    // Seven bits per byte, low group first; continuation bit on all but the end.
    function void push_varint(input logic [63:0] v);
      int n;
      n = 0;
      while (v >= 64'h80 && n < 9) begin
        add_byte({1'b1, v[6:0]}, 1'b0);
        v = v >> 7;
        n++;
      end
      add_byte(v[7:0], 1'b1);
    endfunction

    function void note_field(input logic [63:0] value, input kind_t kind);
      logic [31:0] lo;
      logic [31:0] zz32;
      lo = value[31:0];
      zz32 = {lo[30:0], 1'b0} ^ {32{lo[31]}};
      fields_seen++;
      case (kind)
        KIND_FIX8:  push_fixed({56'd0, value[7:0]}, 1);
        KIND_FIX16: push_fixed({48'd0, value[15:0]}, 2);
        KIND_FIX32: push_fixed({32'd0, lo}, 4);
        KIND_FIX64: push_fixed(value, 8);
        KIND_VAR32: push_varint({32'd0, lo});
        KIND_VAR64: push_varint(value);
        KIND_ZZ32:  push_varint({32'd0, zz32});
        default:    push_varint({value[62:0], 1'b0} ^ {64{value[63]}});
      endcase
    endfunction

    function void check_byte(input logic [7:0] data, input logic last);
      ser_byte_t want;
      if (pending_bytes.size() == 0) begin
        if (failures < MAX_REPORTS)
          $display("unexpected result byte %02h last %0b", data, last);
        failures++;
      end else begin
        want = pending_bytes.pop_front();
        bytes_checked++;
        if (want.data !== data || want.last !== last) begin
          if (failures < MAX_REPORTS)
            $display("byte %0d mismatch: expected %02h last %0b, got %02h last %0b",
                     bytes_checked, want.data, want.last, data, last);
          failures++;
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  vzfe_cfg_if cfg_ch ();
  vzfe_in_if  item_ch ();
  vzfe_out_if result_ch ();

  varint_zigzag_field_encoder dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .item   (item_ch),
    .result (result_ch)
  );

  field_bytes_sb sb = new();

  int idle_pct;
  int stall_pct;
  logic holding;
  int cycle_count;

  always #1 clk = ~clk;

  // Watch all three channels at each edge. Inputs and outputs change only by
  // nonblocking updates, so every read here sees the pre-edge values.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready)
        sb.set_byte_order(cfg_ch.little_endian);
      if (item_ch.valid && item_ch.ready)
        sb.note_field(item_ch.value, kind_t'(item_ch.kind));
      if (result_ch.valid && result_ch.ready)
        sb.check_byte(result_ch.out_byte, result_ch.last);
    end
  end

  // Receiver: stall at random, and refuse everything during a hold-off.
  always @(posedge clk) begin
    result_ch.ready <= !holding && ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: end the run if it hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes still expected",
               cycle_count, sb.outstanding());
      $display("varint_zigzag_field_encoder test failed");
      $finish;
    end
  end

  // Offer one request; keep valid high until ready reads high after an edge. Leave
  // valid high so, with idle_pct zero, back-to-back requests follow without a gap.
  task automatic send_field(input logic [63:0] v, input kind_t k);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.value <= v;
    item_ch.kind  <= k;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
  endtask

  // Advance at least one edge so the last accepted request is noted, then
  // hold until every predicted byte has come out.
  task automatic wait_drained();
    do @(posedge clk); while (sb.outstanding() != 0);
  endtask

  // Write the byte order register; call only while the block is idle.
  task automatic write_byte_order(input logic le);
    cfg_ch.valid <= 1'b1;
    cfg_ch.little_endian <= le;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // A quarter short values so varints of every length show up, a quarter full-width
  // noise, and half small negatives that exercise the zigzag sign path.
  function automatic logic [63:0] random_value();
    logic [63:0] raw;
    logic [63:0] keep;
    int bits;
    raw = {$urandom, $urandom};
    bits = $urandom_range(64);
    keep = (bits == 64) ? '1 : ((64'd1 << bits) - 64'd1);
    case ($urandom_range(3))
      0: return raw;
      1: return raw & keep;
      default: return ~(raw & keep);
    endcase
  endfunction

  task automatic run_phase(input int sender_idle, input int receiver_stall,
                           input logic le, input bit hold_off);
    write_byte_order(le);
    idle_pct <= sender_idle;
    stall_pct <= receiver_stall;
    // Hold the receiver off while requests keep coming, so the queue fills
    // and the block has to back-pressure its input.
    if (hold_off) begin
      fork
        begin
          holding <= 1'b1;
          repeat (HOLD_OFF_CYCLES) @(posedge clk);
          holding <= 1'b0;
        end
      join_none
    end
    repeat (PHASE_FIELDS) send_field(random_value(), kind_t'($urandom_range(7)));
    item_ch.valid <= 1'b0;
    wait_drained();
  endtask

  initial begin
    // Drive every input to a known value before the first edge.
    rst = 1'b1;
    cfg_ch.valid = 1'b0;
    cfg_ch.little_endian = 1'b0;
    item_ch.valid = 1'b0;
    item_ch.value = '0;
    item_ch.kind = KIND_FIX8;
    result_ch.ready = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    holding = 1'b0;
    cycle_count = 0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, big-endian: field extremes and every special case.
    write_byte_order(1'b0);
    send_field(64'hFFFF_FFFF_FFFF_FFA5, KIND_FIX8);    // junk above the byte
    send_field(64'h0123_4567_89AB_CDEF, KIND_FIX16);
    send_field(64'h0123_4567_89AB_CDEF, KIND_FIX32);
    send_field(64'h0123_4567_89AB_CDEF, KIND_FIX64);
    send_field(64'h0, KIND_FIX64);
    send_field(64'h0, KIND_VAR32);                     // varint zero
    send_field(64'h7F, KIND_VAR32);
    send_field(64'h80, KIND_VAR32);
    send_field(64'hDEAD_BEEF_FFFF_FFFF, KIND_VAR32);   // five bytes, junk high
    send_field(64'h0, KIND_VAR64);
    send_field(64'hFFFF_FFFF_FFFF_FFFF, KIND_VAR64);   // ten bytes
    send_field(64'h8000_0000_0000_0000, KIND_VAR64);
    send_field(64'h0, KIND_ZZ32);
    send_field(64'hFFFF_FFFF, KIND_ZZ32);              // minus one
    send_field(64'h1, KIND_ZZ32);
    send_field(64'h1234_5678_8000_0000, KIND_ZZ32);    // minimum wraps to all ones
    send_field(64'h7FFF_FFFF, KIND_ZZ32);
    send_field(64'h0, KIND_ZZ64);
    send_field(64'hFFFF_FFFF_FFFF_FFFF, KIND_ZZ64);
    send_field(64'h8000_0000_0000_0000, KIND_ZZ64);
    send_field(64'h7FFF_FFFF_FFFF_FFFF, KIND_ZZ64);
    item_ch.valid <= 1'b0;
    wait_drained();

    // Same fixed kinds little-endian; the single byte must not move.
    write_byte_order(1'b1);
    send_field(64'hFFFF_FFFF_FFFF_FF5A, KIND_FIX8);
    send_field(64'hFEDC_BA98_7654_3210, KIND_FIX16);
    send_field(64'hFEDC_BA98_7654_3210, KIND_FIX32);
    send_field(64'hFEDC_BA98_7654_3210, KIND_FIX64);
    item_ch.valid <= 1'b0;
    wait_drained();

    // Random part: full rate with a long hold-off, then idle sender,
    // stalling receiver, and both.
    run_phase(0, 0, 1'b1, 1'b1);
    run_phase(55, 0, 1'b0, 1'b0);
    run_phase(0, 55, 1'b1, 1'b0);
    run_phase(27, 27, 1'b0, 1'b0);

    // Wait on for stray bytes before the final check.
    repeat (8) @(posedge clk);
    if (sb.outstanding() != 0) begin
      $display("%0d predicted bytes never arrived", sb.outstanding());
      sb.failures++;
    end

    $display("Encoded %0d fields of all eight kinds into %0d checked bytes,", sb.fields_seen,
             sb.bytes_checked);
    $display("in both byte orders, with idle, stall and long back-pressure phases.");
    if (sb.failures == 0)
      $display("varint_zigzag_field_encoder test passed");
    else
      $display("varint_zigzag_field_encoder test failed");
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/vzfe_pkg.sv
rtl/core/vzfe_if.sv
rtl/core/vzfe_front.sv
rtl/core/vzfe_queue.sv
rtl/core/vzfe_back.sv
rtl/core/varint_zigzag_field_encoder.sv
tb/varint_zigzag_field_encoder_tb.sv
